[rtl/core/dta_pkg.sv]
// Shared types, codes and the threshold test function for the alarm channel.
`timescale 1ns / 1ps

package dta_pkg;

  // Width of a sample, a limit and the widest configuration register.
  localparam int unsigned DATA_W = 32;
  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TEST   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LIMIT  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_TEST  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LIMIT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_TEST = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 4'd7;

  // Test selection codes, shared by all three tests.
  typedef enum logic [2:0] {
    TEST_NONE = 3'd0,
    TEST_GT   = 3'd1,
    TEST_GE   = 3'd2,
    TEST_LT   = 3'd3,
    TEST_LE   = 3'd4,
    TEST_EQ   = 3'd5,
    TEST_AND  = 3'd6,
    TEST_OR   = 3'd7
  } test_code_t;

  // Debounce phases.
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_ARMED     = 2'd1,
    PH_ACTIVATED = 2'd2,
    PH_CLEARED   = 2'd3
  } phase_t;

  // Threshold settings handed to the condition unit.
  typedef struct packed {
    test_code_t               first_test;
    logic signed [DATA_W-1:0] first_limit;
    test_code_t               second_test;
    logic signed [DATA_W-1:0] second_limit;
    test_code_t               combine_test;
  } cond_cfg_t;

  // Applies one test to a value and a limit, both signed.
  function automatic logic apply_test(test_code_t code, logic signed [DATA_W-1:0] v,
                                      logic signed [DATA_W-1:0] lim);
    logic r;
    unique case (code)
      TEST_NONE: r = 1'b1;
      TEST_GT:   r = (v > lim);
      TEST_GE:   r = (v >= lim);
      TEST_LT:   r = (v < lim);
      TEST_LE:   r = (v <= lim);
      TEST_EQ:   r = (v == lim);
      TEST_AND:  r = (v != '0) && (lim != '0);
      TEST_OR:   r = (v != '0) || (lim != '0);
      default:   r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/dta_cond.sv]
// Threshold condition unit: two limit tests and the test that combines them.
`timescale 1ns / 1ps

module dta_cond import dta_pkg::*; (
  input  logic signed [DATA_W-1:0] sample,
  input  cond_cfg_t                cfg,
  output logic                     cond
);

  logic first_hit;
  logic second_hit;

  assign first_hit  = apply_test(cfg.first_test, sample, cfg.first_limit);
  assign second_hit = apply_test(cfg.second_test, sample, cfg.second_limit);

  // The two results enter the combining test as the signed values 0 or 1.
  assign cond = apply_test(cfg.combine_test,
                           $signed({{(DATA_W-1){1'b0}}, first_hit}),
                           $signed({{(DATA_W-1){1'b0}}, second_hit}));

endmodule

[rtl/core/debounced_threshold_alarm.sv]
// Top level of the debounced threshold alarm channel.
`timescale 1ns / 1ps

// One alarm channel. Each input word carries a signed Q16.16 sample and the current
// millisecond time; each produces exactly one result word with the armed condition, the
// sticky active flag, the debounce phase and a one-word clear_sensor pulse. While enable is
// set, the sample is tested against first_limit and second_limit and combine_test merges
// the two outcomes into the armed condition. The phase machine then moves from idle to armed
// when the condition appears, to activated once it has held for debounce_ms (setting the
// active flag, which only reset clears), and to cleared once hold_ms has passed in the
// activated phase, which is the word that carries clear_sensor; the next enabled word
// returns it to idle. Time differences wrap modulo 2^TIME_WIDTH. While enable is clear a
// word changes nothing and reports the held state. The block takes one word per clock
// cycle while out_ready keeps the result register free: a word waits in the input
// register, and the threshold tests, the time difference and the phase update happen
// between that register and the result register, which presents the result word on the
// outputs. The input register keeps accepting while a result waits, as long as it is
// empty itself or the result register frees up in the same cycle.
// Configuration registers are written through cfg_we, cfg_index and cfg_data with no wait;
// an index beyond the eight registers is ignored. Write them only while no word is in flight.

module debounced_threshold_alarm import dta_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // input words
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] sensor_value,
  input  logic [DATA_W-1:0]        now_ms,
  // result words
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     armed,
  output logic                     active,
  output logic [1:0]               phase,
  output logic                     clear_sensor
);

  // Wide enough to hold both a 32-bit time and a TIME_WIDTH time.
  localparam int unsigned EXT_W = (TIME_WIDTH > DATA_W) ? TIME_WIDTH : DATA_W;

  // Configuration registers.
  logic              enable;
  cond_cfg_t         cond_cfg;
  logic [DATA_W-1:0] debounce_ms;
  logic [DATA_W-1:0] hold_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      cond_cfg    <= '{first_test: TEST_NONE, first_limit: '0, second_test: TEST_NONE,
                       second_limit: '0, combine_test: TEST_NONE};
      debounce_ms <= '0;
      hold_ms     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:       enable                <= cfg_data[0];
        REG_FIRST_TEST:   cond_cfg.first_test   <= test_code_t'(cfg_data[2:0]);
        REG_FIRST_LIMIT:  cond_cfg.first_limit  <= $signed(cfg_data);
        REG_SECOND_TEST:  cond_cfg.second_test  <= test_code_t'(cfg_data[2:0]);
        REG_SECOND_LIMIT: cond_cfg.second_limit <= $signed(cfg_data);
        REG_COMBINE_TEST: cond_cfg.combine_test <= test_code_t'(cfg_data[2:0]);
        REG_DEBOUNCE_MS:  debounce_ms           <= cfg_data;
        REG_HOLD_MS:      hold_ms               <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic                     s1_valid;
  logic signed [DATA_W-1:0] s1_sample;
  logic [DATA_W-1:0]        s1_now;
  logic                     out_free;
  logic                     step;

  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample <= sensor_value;
      s1_now    <= now_ms;
    end
  end

  // Threshold condition for the registered sample.
  logic cond;

  dta_cond u_cond (
    .sample (s1_sample),
    .cfg    (cond_cfg),
    .cond   (cond)
  );

  // Times are carried at TIME_WIDTH bits: the 32-bit fields are zero-extended or cut.
  logic [EXT_W-1:0]      now_ext;
  logic [EXT_W-1:0]      debounce_ext;
  logic [EXT_W-1:0]      hold_ext;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;

  assign now_ext      = EXT_W'(s1_now);
  assign debounce_ext = EXT_W'(debounce_ms);
  assign hold_ext     = EXT_W'(hold_ms);
  assign now_t        = now_ext[TIME_WIDTH-1:0];

  // Channel state.
  phase_t                phase_reg, phase_next;
  logic [TIME_WIDTH-1:0] mark_time, mark_time_next;
  logic                  armed_flag, armed_flag_next;
  logic                  active_flag, active_flag_next;
  logic                  pulse;

  // The difference wraps naturally at TIME_WIDTH bits.
  assign elapsed = now_t - mark_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= PH_IDLE;
      mark_time   <= '0;
      armed_flag  <= 1'b0;
      active_flag <= 1'b0;
    end else if (step) begin
      phase_reg   <= phase_next;
      mark_time   <= mark_time_next;
      armed_flag  <= armed_flag_next;
      active_flag <= active_flag_next;
    end
  end

  always_comb begin
    phase_next       = phase_reg;
    mark_time_next   = mark_time;
    armed_flag_next  = armed_flag;
    active_flag_next = active_flag;
    pulse            = 1'b0;
    if (enable) begin
      armed_flag_next = cond;
      unique case (phase_reg)
        PH_IDLE: begin
          if (cond) begin
            mark_time_next = now_t;
            phase_next     = PH_ARMED;
          end
        end
        PH_ARMED: begin
          if (!cond) begin
            phase_next = PH_IDLE;
          end else if (elapsed >= debounce_ext[TIME_WIDTH-1:0]) begin
            active_flag_next = 1'b1;
            mark_time_next   = now_t;
            phase_next       = PH_ACTIVATED;
          end
        end
        PH_ACTIVATED: begin
          if (elapsed >= hold_ext[TIME_WIDTH-1:0]) begin
            pulse      = 1'b1;
            phase_next = PH_CLEARED;
          end
        end
        PH_CLEARED: begin
          // Back to idle without testing for a new debounce on this word.
          phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      armed        <= armed_flag_next;
      active       <= active_flag_next;
      phase        <= phase_next;
      clear_sensor <= pulse;
    end
  end

  // The clear pulse is only ever reported with the cleared phase.
  a_pulse_in_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clear_sensor) |-> (phase == PH_CLEARED))
    else $error("clear_sensor reported outside the cleared phase");

  // Once set, the active flag stays set until reset.
  a_active_sticky: assert property (@(posedge clk) disable iff (rst)
    active_flag |=> active_flag)
    else $error("active flag dropped without reset");

  // The activated and cleared phases can only be reached through activation.
  a_phase_needs_active: assert property (@(posedge clk) disable iff (rst)
    ((phase_reg == PH_ACTIVATED) || (phase_reg == PH_CLEARED)) |-> active_flag)
    else $error("late phase without the active flag");

  // A word taken while disabled leaves the phase untouched.
  a_disabled_holds: assert property (@(posedge clk) disable iff (rst)
    (step && !enable) |=> $stable(phase_reg))
    else $error("phase moved while the channel was disabled");

endmodule

[sim/dta_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts the alarm channel's result words and compares them as they leave.

module dta_checker import dta_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [DATA_W-1:0] sensor_value,
  input  logic [DATA_W-1:0]        now_ms,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     armed,
  input  logic                     active,
  input  logic [1:0]               phase,
  input  logic                     clear_sensor,
  output int                       fail_count,
  output int                       pending_count
);

  typedef struct packed {
    logic   armed;
    logic   active;
    phase_t phase;
    logic   clear;
  } alarm_word_t;

  // Mirror of the configuration registers.
  logic                     chan_on;
  test_code_t               first_rule;
  test_code_t               second_rule;
  test_code_t               merge_rule;
  logic signed [DATA_W-1:0] first_lim;
  logic signed [DATA_W-1:0] second_lim;
  logic [DATA_W-1:0]        debounce_len;
  logic [DATA_W-1:0]        hold_len;

  // Mirror of the channel state.
  phase_t            stage;
  logic [DATA_W-1:0] stamp;
  logic              armed_now;
  logic              active_now;

  alarm_word_t expected_words[$];
  int          errors = 0;

  assign fail_count = errors;

  function automatic logic rule_holds(test_code_t code, logic signed [DATA_W-1:0] a,
                                      logic signed [DATA_W-1:0] b);
    case (code)
      TEST_NONE: return 1'b1;
      TEST_GT:   return a > b;
      TEST_GE:   return a >= b;
      TEST_LT:   return a < b;
      TEST_LE:   return a <= b;
      TEST_EQ:   return a == b;
      TEST_AND:  return (a != 0) && (b != 0);
      default:   return (a != 0) || (b != 0);
    endcase
  endfunction

  task automatic log_fault(input string msg);
    errors++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Advances the mirrored channel by one input word and returns the word it should emit.
  task automatic step_channel(input logic signed [DATA_W-1:0] v, input logic [DATA_W-1:0] t,
                              output alarm_word_t w);
    logic [DATA_W-1:0] elapsed;
    logic              hit_a;
    logic              hit_b;
    logic              pulse;
    pulse = 1'b0;
    if (chan_on) begin
      elapsed = t - stamp;
      hit_a = rule_holds(first_rule, v, first_lim);
      hit_b = rule_holds(second_rule, v, second_lim);
      armed_now = rule_holds(merge_rule, {31'd0, hit_a}, {31'd0, hit_b});
      case (stage)
        PH_IDLE: begin
          if (armed_now) begin
            stamp = t;
            stage = PH_ARMED;
          end
        end
        PH_ARMED: begin
          if (!armed_now) begin
            stage = PH_IDLE;
          end else if (elapsed >= debounce_len) begin
            active_now = 1'b1;
            stamp = t;
            stage = PH_ACTIVATED;
          end
        end
        PH_ACTIVATED: begin
          if (elapsed >= hold_len) begin
            pulse = 1'b1;
            stage = PH_CLEARED;
          end
        end
        default: stage = PH_IDLE;
      endcase
    end
    w = '{armed: armed_now, active: active_now, phase: stage, clear: pulse};
  endtask

  always @(posedge clk) begin : monitor
    alarm_word_t want;
    alarm_word_t fresh;
    if (rst) begin
      chan_on = 1'b0;
      first_rule = TEST_NONE;
      second_rule = TEST_NONE;
      merge_rule = TEST_NONE;
      first_lim = '0;
      second_lim = '0;
      debounce_len = '0;
      hold_len = '0;
      stage = PH_IDLE;
      stamp = '0;
      armed_now = 1'b0;
      active_now = 1'b0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          log_fault("result word with no expectation waiting");
        end else begin
          want = expected_words.pop_front();
          if (armed !== want.armed)
            log_fault($sformatf("armed got %b expected %b", armed, want.armed));
          if (active !== want.active)
            log_fault($sformatf("active got %b expected %b", active, want.active));
          if (phase !== want.phase)
            log_fault($sformatf("phase got %0d expected %0d", phase, want.phase));
          if (clear_sensor !== want.clear)
            log_fault($sformatf("clear_sensor got %b expected %b", clear_sensor, want.clear));
        end
      end
      if (in_valid && in_ready) begin
        step_channel(sensor_value, now_ms, fresh);
        expected_words.push_back(fresh);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:       chan_on = cfg_data[0];
          REG_FIRST_TEST:   first_rule = test_code_t'(cfg_data[2:0]);
          REG_FIRST_LIMIT:  first_lim = cfg_data;
          REG_SECOND_TEST:  second_rule = test_code_t'(cfg_data[2:0]);
          REG_SECOND_LIMIT: second_lim = cfg_data;
          REG_COMBINE_TEST: merge_rule = test_code_t'(cfg_data[2:0]);
          REG_DEBOUNCE_MS:  debounce_len = cfg_data;
          REG_HOLD_MS:      hold_len = cfg_data;
          default: ;
        endcase
      end
    end
    pending_count <= expected_words.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top: drives stimulus into the alarm channel and reports the verdict.

module tb_top;
  import dta_pkg::*;

  // Generous ceiling on the run.
  localparam int CYCLE_LIMIT = 300000;
  // Register indexes past the end of the register list; writes to them must be dropped.
  localparam int FIRST_UNUSED_REG = 8;
  localparam int LAST_UNUSED_REG  = 15;

  // How the result side applies back-pressure during one stretch of cycles.
  typedef enum logic [1:0] {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] sensor_value = '0;
  logic [DATA_W-1:0]        now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     armed;
  logic                     active;
  logic [1:0]               phase;
  logic                     clear_sensor;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left = 1;

  // The limits currently programmed, so that samples can be aimed at the thresholds.
  logic signed [DATA_W-1:0] lim_a = '0;
  logic signed [DATA_W-1:0] lim_b = '0;

  rx_mode_t rx_mode = RX_FLOW;
  int       rx_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  debounced_threshold_alarm u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sensor_value (sensor_value),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .armed        (armed),
    .active       (active),
    .phase        (phase),
    .clear_sensor (clear_sensor)
  );

  dta_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sensor_value  (sensor_value),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .armed         (armed),
    .active        (active),
    .phase         (phase),
    .clear_sensor  (clear_sensor),
    .fail_count    (fail_count),
    .pending_count (pending)
  );

  // The result side stalls on a pattern of its own. Each stretch picks a mode: flowing
  // freely, light random stalls, heavy random stalls, or a fixed one-in-five opening.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_FLOW:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= (rx_left % 5 == 0);
    endcase
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL debounced_threshold_alarm");
      $finish;
    end
  end

  // One register write; the enable is lowered on the following falling edge.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stops offering words and waits until every expected result word has been taken.
  // Every word yields exactly one result, so an empty expectation store means the block
  // holds nothing in flight and may be reconfigured.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Reprograms the whole channel while it is idle. A write to an index past the register
  // list follows, with all bits set, so that an aliased decode would corrupt a setting.
  task automatic program_channel(input logic en, input test_code_t rule_a,
                                 input logic signed [DATA_W-1:0] limit_a,
                                 input test_code_t rule_b,
                                 input logic signed [DATA_W-1:0] limit_b,
                                 input test_code_t rule_merge,
                                 input logic [DATA_W-1:0] debounce,
                                 input logic [DATA_W-1:0] hold);
    wait_idle();
    cfg_write(REG_ENABLE, {31'd0, en});
    cfg_write(REG_FIRST_TEST, {29'd0, rule_a});
    cfg_write(REG_FIRST_LIMIT, limit_a);
    cfg_write(REG_SECOND_TEST, {29'd0, rule_b});
    cfg_write(REG_SECOND_LIMIT, limit_b);
    cfg_write(REG_COMBINE_TEST, {29'd0, rule_merge});
    cfg_write(REG_DEBOUNCE_MS, debounce);
    cfg_write(REG_HOLD_MS, hold);
    cfg_write(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)), '1);
    lim_a = limit_a;
    lim_b = limit_b;
  endtask

  // Offers one word at the falling edge and returns once it has been accepted. The sender
  // works in bursts: when a burst runs out, valid drops for a random gap, and sometimes the
  // gap is zero so that long stretches run back to back.
  task automatic send_word(input logic signed [DATA_W-1:0] v, input logic [DATA_W-1:0] t);
    int gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    sensor_value <= v;
    now_ms       <= t;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Thresholds: the extremes of the Q16.16 range, zero, anything, or mostly small values
  // within about two units of zero so that samples straddle them often.
  function automatic logic signed [DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return $urandom;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // Periods: mostly short so the phase machine walks all the way round, with the zero and
  // full-scale extremes mixed in.
  function automatic logic [DATA_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0]        t;
    logic signed [DATA_W-1:0] val;
    int                       run_left;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Straight after reset the channel is disabled, so these words must only report the
    // held reset state, whatever the sample and time.
    send_word(32'sh7FFF_FFFF, 32'h0000_0000);
    send_word(32'sh8000_0000, 32'hFFFF_FFFF);

    // Zero periods: the machine still takes one word per step, and a zero time difference
    // satisfies the period. The activated phase ignores the armed condition.
    program_channel(1'b1, TEST_GT, '0, TEST_NONE, '0, TEST_AND, '0, '0);
    send_word(32'sd5, 32'd100);
    send_word(32'sd5, 32'd100);
    send_word(-32'sd3, 32'd100);
    send_word(-32'sd3, 32'd101);

    // Every test code, used by all three tests; the second test takes the codes in reverse order.
    for (int c = 0; c < 8; c++) begin
      program_channel(1'b1, test_code_t'(c), 32'sh0001_0000, test_code_t'(7 - c),
                      32'sh8000_0000, test_code_t'(c), '0, '0);
      send_word((c % 2 != 0) ? 32'sh0001_0000 : 32'sh0000_8000, 32'd200 + c);
    end

    // Full-scale debounce, satisfied only by a difference of all ones (time stepping back
    // by one), then a hold period that is crossed as the time counter wraps through zero.
    program_channel(1'b1, TEST_NONE, 32'sh7FFF_FFFF, TEST_NONE, 32'sh8000_0000, TEST_NONE,
                    32'hFFFF_FFFF, 32'd20);
    send_word(32'sh7FFF_FFFF, 32'hFFFF_FFF0);
    send_word(32'sh8000_0000, 32'hFFFF_FFEF);
    send_word(-32'sd1, 32'h0000_0004);
    send_word('0, 32'h0000_0005);

    // Random phases, each with fresh settings. Most words form runs of one sample aimed at
    // or next to a threshold, with time moving forward in small steps, so that the armed
    // condition holds long enough to debounce, activate and clear. About one word in eight
    // is noise: any sample at any time, which breaks runs and throws time around.
    for (int p = 0; p < 8; p++) begin
      program_channel(($urandom_range(0, 7) != 0), test_code_t'($urandom_range(0, 7)),
                      pick_limit(), test_code_t'($urandom_range(0, 7)), pick_limit(),
                      test_code_t'($urandom_range(0, 7)), pick_period(), pick_period());
      t = $urandom;
      run_left = 0;
      for (int i = 0; i < 80; i++) begin
        // Halfway through the first phase, and now and then later, the sender holds off
        // until every result word has drained.
        if (i == 40 && (p == 0 || $urandom_range(0, 2) == 0)) wait_idle();
        if ($urandom_range(0, 7) == 0) begin
          t = $urandom;
          send_word($urandom, t);
        end else begin
          if (run_left == 0) begin
            run_left = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
              0:       val = lim_a;
              1:       val = lim_a + 1;
              2:       val = lim_a - 1;
              3:       val = lim_b;
              4:       val = lim_b + 1;
              5:       val = lim_b - 1;
              6:       val = '0;
              7:       val = 32'sh7FFF_FFFF;
              8:       val = 32'sh8000_0000;
              default: val = $urandom;
            endcase
          end
          run_left--;
          t = t + $urandom_range(0, 12);
          send_word(val, t);
        end
      end
    end

    // Drain, then let any stray word show before the verdict.
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS debounced_threshold_alarm");
    end else begin
      $display("FAIL debounced_threshold_alarm");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/dta_pkg.sv
rtl/core/dta_cond.sv
rtl/core/debounced_threshold_alarm.sv
sim/dta_checker.sv
sim/tb_top.sv
